FILE: src/hgpp_pkg.sv
// Shared types and constants for the hex grid point picker.
`timescale 1ns / 1ps
`default_nettype none
package hgpp_pkg;

  localparam int GRID_SIZE_DEF = 8;
  localparam int RAD_W         = 10;
  localparam int PT_W          = 16;
  localparam int IDX_OUT_W     = 3;
  localparam int H_W           = 15;
  localparam int VSTEP_W       = 15;
  localparam int COORD_W       = 24;
  localparam int D2_W          = 2 * COORD_W;
  localparam int HPROD_W       = 27;
  localparam logic [PT_W-1:0]  SIN60_Q16   = 16'd56756;
  localparam logic [RAD_W-1:0] RADIUS_RST  = 10'd50;

  localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] REG_CELL_RADIUS = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
    logic busy;
  } status_t;

endpackage
`default_nettype wire

FILE: src/hgpp_ctrl.sv
// Controller: sequences setup, cell scan, pipeline drain and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module hgpp_ctrl import hgpp_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  wire     out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_stall    = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.last_cell) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.busy) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/hgpp_dp.sv
// Datapath: cell center stepping, distance pipeline, best-cell tracking, result register.
`timescale 1ns / 1ps
`default_nettype none
module hgpp_dp import hgpp_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  wire signed [PT_W-1:0] point_x,
  input  wire signed [PT_W-1:0] point_y,
  input  wire signed [PT_W-1:0] origin_x,
  input  wire signed [PT_W-1:0] origin_y,
  input  wire [RAD_W-1:0]      cell_radius,
  output logic                 hit,
  output logic [IDX_OUT_W-1:0] cell_q,
  output logic [IDX_OUT_W-1:0] cell_r
);

  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GRID_SIZE - 1);

  logic signed [COORD_W-1:0] px, py;
  logic [H_W-1:0]            h;
  logic [VSTEP_W-1:0]        vstep;
  logic [D2_W-1:0]           limit;
  logic [HPROD_W-1:0]        h_prod;
  logic [2*RAD_W-1:0]        rad_sq;
  logic signed [COORD_W-1:0] h_s, vstep_s;

  logic [IDX_W-1:0]          rcnt, qcnt;
  logic signed [COORD_W-1:0] cx, cx_row, cy, cx_row_next;

  logic                      v1, v2;
  logic signed [COORD_W-1:0] dx, dy;
  logic [IDX_W-1:0]          r1, q1, r2, q2;
  logic signed [D2_W-1:0]    sq_x, sq_y;
  logic [D2_W-1:0]           d2;

  logic                      have;
  logic [D2_W-1:0]           best;
  logic [IDX_W-1:0]          best_r, best_q;
  logic [IDX_W+IDX_OUT_W-1:0] q_ext, r_ext;

  assign h_prod      = HPROD_W'(cell_radius) * HPROD_W'(SIN60_Q16) + HPROD_W'(2048);
  assign rad_sq      = (2*RAD_W)'(cell_radius) * (2*RAD_W)'(cell_radius);
  assign h_s         = $signed(COORD_W'(h));
  assign vstep_s     = $signed(COORD_W'(vstep));
  assign cx_row_next = cx_row + h_s;
  assign d2          = $unsigned(sq_x) + $unsigned(sq_y);

  assign status = '{last_cell: (rcnt == IDX_LAST) && (qcnt == IDX_LAST),
                    busy:      v1 || v2};

  // setup and center stepping
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px     <= COORD_W'(point_x);
      py     <= COORD_W'(point_y);
      h      <= h_prod[HPROD_W-1:12];
      vstep  <= (VSTEP_W'(cell_radius) << 4) + (VSTEP_W'(cell_radius) << 3);
      limit  <= D2_W'(rad_sq) << 8;
      rcnt   <= '0;
      qcnt   <= '0;
      cx     <= COORD_W'(origin_x);
      cx_row <= COORD_W'(origin_x);
      cy     <= COORD_W'(origin_y);
    end else if (cmd.scan) begin
      if (qcnt == IDX_LAST) begin
        qcnt   <= '0;
        rcnt   <= rcnt + 1'b1;
        cx_row <= cx_row_next;
        cx     <= cx_row_next;
        cy     <= cy + vstep_s;
      end else begin
        qcnt <= qcnt + 1'b1;
        cx   <= cx + (h_s <<< 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.scan;
      v2 <= v1;
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    dx   <= px - cx;
    dy   <= py - cy;
    r1   <= rcnt;
    q1   <= qcnt;
    sq_x <= dx * dx;
    sq_y <= dy * dy;
    r2   <= r1;
    q2   <= q1;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      have <= 1'b0;
    end else if (v2 && (!have || d2 < best)) begin
      have   <= 1'b1;
      best   <= d2;
      best_r <= r2;
      best_q <= q2;
    end
  end

  assign q_ext = (IDX_W + IDX_OUT_W)'(best_q);
  assign r_ext = (IDX_W + IDX_OUT_W)'(best_r);

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (have && best <= limit) begin
        hit    <= 1'b1;
        cell_q <= q_ext[IDX_OUT_W-1:0];
        cell_r <= r_ext[IDX_OUT_W-1:0];
      end else begin
        hit    <= 1'b0;
        cell_q <= '0;
        cell_r <= '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/hex_grid_point_picker.sv
// Each input beat starts a scan of all GRID_SIZE*GRID_SIZE cells, one cell distance evaluated
// per cycle by the shared square-and-compare pipeline. One item is processed at a time;
// the next input beat is taken while a finished result still waits in the output register.
// Reset: synchronous, active high; clears control, origin to 0, cell_radius to 50.
`timescale 1ns / 1ps
`default_nettype none
module hex_grid_point_picker import hgpp_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [1:0]             cfg_index,
  input  wire [PT_W-1:0]        cfg_data,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire signed [PT_W-1:0] point_x,
  input  wire signed [PT_W-1:0] point_y,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  hit,
  output logic [IDX_OUT_W-1:0]  cell_q,
  output logic [IDX_OUT_W-1:0]  cell_r
);

  logic signed [PT_W-1:0] origin_x, origin_y;
  logic [RAD_W-1:0]       cell_radius;
  cmd_t                   cmd;
  status_t                status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      cell_radius <= RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:    origin_x    <= cfg_data;
        REG_ORIGIN_Y:    origin_y    <= cfg_data;
        REG_CELL_RADIUS: cell_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  hgpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  hgpp_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .point_x     (point_x),
    .point_y     (point_y),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .cell_radius (cell_radius),
    .hit         (hit),
    .cell_q      (cell_q),
    .cell_r      (cell_r)
  );

endmodule
`default_nettype wire
